>>> src/otq_pkg.sv
// Shared types, codes and helpers of the ordered timer queue.
`default_nettype none
package otq_pkg;
   localparam int TimeW  = 48;
   localparam int IntvW  = 32;
   localparam int DelayW = 16;
   localparam int HandW  = 4;
   localparam int KindW  = 2;

   localparam logic [DelayW-1:0] MinDelayReset = 16'd100;
   localparam logic [TimeW-1:0]  TimeMax       = {TimeW{1'b1}};

   localparam logic FuncAdd    = 1'b0;
   localparam logic FuncExpire = 1'b1;

   localparam logic [KindW-1:0] KindAddAck  = 2'd0;
   localparam logic [KindW-1:0] KindExpired = 2'd1;
   localparam logic [KindW-1:0] KindSummary = 2'd2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FIN,
      ST_DLY,
      ST_RLD_RD,
      ST_RLD_WR,
      ST_OUT
   } state_type;

   typedef enum logic [1:0] {
      SCAN_MIN,
      SCAN_DUE,
      SCAN_PICK
   } scan_type;

   typedef struct packed {
      logic [KindW-1:0] kind;
      logic [HandW-1:0] handle;
      logic             status;
      logic             earliest;
      logic             dvalid;
      logic [TimeW-1:0] deadline;
      logic [TimeW-1:0] delay;
      logic             last;
   } result_type;

   function automatic logic [HandW-1:0] handle_of(input logic [7:0] idx);
      return idx[HandW-1:0];
   endfunction
endpackage
`default_nettype wire

>>> src/otq_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module otq_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(Depth)-1:0] wr_addr,
   input  wire logic [Width-1:0]         wr_data,
   input  wire logic [$clog2(Depth)-1:0] rd_addr,
   output logic      [Width-1:0]         rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule
`default_nettype wire

>>> src/ordered_timer_queue.sv
// Top level of the ordered timer queue: control sequencer, slot memories and result register.
// One item at a time. An add makes one pass over the expiry memory (one slot per cycle)
// that finds a free slot, the earliest flag and the next deadline. An expire makes a pass
// that marks the due slots, one pass per emitted timer to pick the earliest due one with a
// read-modify-write of that slot, and a final pass for the next deadline. Each result waits
// in the output register until taken. Slot valid bits are flip-flops cleared by reset;
// expiry and interval contents are undefined until written.
`default_nettype none
module ordered_timer_queue #(
   parameter int CAPACITY = 16
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   output logic                           req_tready,
   // time_us[47:0], interval_us[79:48], now_us[127:80]
   input  wire logic [127:0]              req_tdata,
   // func
   input  wire logic                      req_tuser,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   // timer_handle[3:0], status[4], is_earliest[5], deadline_valid[6],
   // next_deadline_us[54:7], arm_delay_us[102:55], zero[103]
   output logic [103:0]                   rsp_tdata,
   // kind
   output logic [otq_pkg::KindW-1:0]      rsp_tuser,
   output logic                           rsp_tlast,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic [otq_pkg::DelayW-1:0] csr_data
);
   import otq_pkg::*;

   localparam int IW = $clog2(CAPACITY);

   state_type state_ff, state_in;
   scan_type  mode_ff, mode_in;
   logic      scan_init;

   logic [IW:0]        cnt_ff, cnt_in;
   logic               func_ff, func_in;
   logic [TimeW-1:0]   t_ff, t_in;
   logic [IntvW-1:0]   intv_ff, intv_in;
   logic [TimeW-1:0]   now_ff, now_in;
   logic [DelayW-1:0]  min_delay_ff, min_delay_in;
   logic [CAPACITY-1:0] valid_ff, valid_in;
   logic [CAPACITY-1:0] due_ff, due_in;
   logic               any_ff, any_in;
   logic [TimeW-1:0]   best_ff, best_in;
   logic               free_any_ff, free_any_in;
   logic [IW-1:0]      free_ff, free_in;
   logic               earliest_ff, earliest_in;
   logic               pick_any_ff, pick_any_in;
   logic [IW-1:0]      pick_ff, pick_in;
   logic [TimeW-1:0]   pick_exp_ff, pick_exp_in;
   result_type         res_ff, res_in;

   logic               exp_we, int_we;
   logic [IW-1:0]      exp_waddr, exp_raddr, int_raddr;
   logic [TimeW-1:0]   exp_wdata, exp_rdata;
   logic [IntvW-1:0]   int_rdata;

   logic               scan_proc, scan_last;
   logic [IW-1:0]      pidx;
   logic [TimeW:0]     reload_sum;
   logic [TimeW-1:0]   ref_now, diff, clamp;

   assign scan_proc = (state_ff == ST_SCAN) && (cnt_ff != '0);
   assign scan_last = (state_ff == ST_SCAN) && (cnt_ff == (IW+1)'(CAPACITY));
   assign pidx      = IW'(cnt_ff - 1'b1);

   otq_ram #(.Width(TimeW), .Depth(CAPACITY)) u_expiry (
      .clock   (clock),
      .wr_en   (exp_we),
      .wr_addr (exp_waddr),
      .wr_data (exp_wdata),
      .rd_addr (exp_raddr),
      .rd_data (exp_rdata)
   );

   otq_ram #(.Width(IntvW), .Depth(CAPACITY)) u_interval (
      .clock   (clock),
      .wr_en   (int_we),
      .wr_addr (free_ff),
      .wr_data (intv_ff),
      .rd_addr (int_raddr),
      .rd_data (int_rdata)
   );

   // next state
   always_comb begin
      state_in  = state_ff;
      mode_in   = mode_ff;
      scan_init = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               state_in  = ST_SCAN;
               mode_in   = (req_tuser == FuncAdd) ? SCAN_MIN : SCAN_DUE;
               scan_init = 1'b1;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               unique case (mode_ff)
                  SCAN_MIN: state_in = ST_FIN;
                  SCAN_DUE: begin
                     mode_in   = SCAN_PICK;
                     scan_init = 1'b1;
                  end
                  SCAN_PICK: begin
                     if (pick_any_ff || due_ff[pidx]) begin
                        state_in = ST_RLD_RD;
                     end else begin
                        mode_in   = SCAN_MIN;
                        scan_init = 1'b1;
                     end
                  end
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_FIN:    state_in = ST_DLY;
         ST_DLY:    state_in = ST_OUT;
         ST_RLD_RD: state_in = ST_RLD_WR;
         ST_RLD_WR: state_in = ST_OUT;
         ST_OUT: begin
            if (rsp_tready) begin
               if (res_ff.last) begin
                  state_in = ST_IDLE;
               end else begin
                  state_in  = ST_SCAN;
                  mode_in   = SCAN_PICK;
                  scan_init = 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // outputs and memory control
   always_comb begin
      req_tready = (state_ff == ST_IDLE);
      rsp_tvalid = (state_ff == ST_OUT);
      csr_ready  = 1'b1;
      exp_raddr  = cnt_ff[IW-1:0];
      int_raddr  = pick_ff;
      exp_we     = 1'b0;
      exp_waddr  = free_ff;
      exp_wdata  = t_ff;
      int_we     = 1'b0;
      unique case (state_ff)
         ST_FIN: begin
            exp_we = (func_ff == FuncAdd) && free_any_ff;
            int_we = (func_ff == FuncAdd) && free_any_ff;
         end
         ST_RLD_WR: begin
            exp_we    = (int_rdata != '0);
            exp_waddr = pick_ff;
            exp_wdata = reload_sum[TimeW] ? TimeMax : reload_sum[TimeW-1:0];
         end
         default: begin
         end
      endcase
   end

   assign reload_sum = {1'b0, t_ff} + {{(TimeW+1-IntvW){1'b0}}, int_rdata};
   assign ref_now    = (func_ff == FuncAdd) ? now_ff : t_ff;
   assign diff       = (best_ff > ref_now) ? best_ff - ref_now : '0;
   assign clamp      = (diff < {{(TimeW-DelayW){1'b0}}, min_delay_ff})
                       ? {{(TimeW-DelayW){1'b0}}, min_delay_ff} : diff;

   // datapath
   always_comb begin
      cnt_in       = cnt_ff;
      func_in      = func_ff;
      t_in         = t_ff;
      intv_in      = intv_ff;
      now_in       = now_ff;
      min_delay_in = min_delay_ff;
      valid_in     = valid_ff;
      due_in       = due_ff;
      any_in       = any_ff;
      best_in      = best_ff;
      free_any_in  = free_any_ff;
      free_in      = free_ff;
      earliest_in  = earliest_ff;
      pick_any_in  = pick_any_ff;
      pick_in      = pick_ff;
      pick_exp_in  = pick_exp_ff;
      res_in       = res_ff;

      if (csr_valid) begin
         min_delay_in = csr_data;
      end
      if (state_ff == ST_IDLE && req_tvalid) begin
         func_in = req_tuser;
         t_in    = req_tdata[47:0];
         intv_in = req_tdata[79:48];
         now_in  = req_tdata[127:80];
      end
      if (state_ff == ST_SCAN) begin
         cnt_in = cnt_ff + 1'b1;
      end
      if (scan_proc) begin
         unique case (mode_ff)
            SCAN_MIN: begin
               if (valid_ff[pidx] && (!any_ff || exp_rdata < best_ff)) begin
                  any_in  = 1'b1;
                  best_in = exp_rdata;
               end
               if (!valid_ff[pidx] && !free_any_ff) begin
                  free_any_in = 1'b1;
                  free_in     = pidx;
               end
               if (valid_ff[pidx] && !(t_ff < exp_rdata)) begin
                  earliest_in = 1'b0;
               end
            end
            SCAN_DUE: due_in[pidx] = valid_ff[pidx] && (exp_rdata <= t_ff);
            SCAN_PICK: begin
               if (due_ff[pidx] && (!pick_any_ff || exp_rdata < pick_exp_ff)) begin
                  pick_any_in = 1'b1;
                  pick_in     = pidx;
                  pick_exp_in = exp_rdata;
               end
            end
            default: begin
            end
         endcase
      end
      if (scan_init) begin
         cnt_in      = '0;
         any_in      = 1'b0;
         free_any_in = 1'b0;
         earliest_in = 1'b1;
      end
      if (scan_init && (state_ff != ST_SCAN || mode_ff != SCAN_PICK)) begin
         pick_any_in = 1'b0;
      end

      unique case (state_ff)
         ST_FIN: begin
            if (func_ff == FuncAdd && free_any_ff) begin
               valid_in[free_ff] = 1'b1;
               any_in            = 1'b1;
               best_in           = (!any_ff || t_ff < best_ff) ? t_ff : best_ff;
            end
         end
         ST_DLY: begin
            res_in.kind     = (func_ff == FuncAdd) ? KindAddAck : KindSummary;
            res_in.handle   = (func_ff == FuncAdd && free_any_ff)
                              ? handle_of(8'(free_ff)) : '0;
            res_in.status   = (func_ff == FuncAdd) && !free_any_ff;
            res_in.earliest = (func_ff == FuncAdd) && free_any_ff && earliest_ff;
            res_in.dvalid   = any_ff;
            res_in.deadline = any_ff ? best_ff : '0;
            res_in.delay    = any_ff ? clamp : '0;
            res_in.last     = 1'b1;
         end
         ST_RLD_WR: begin
            due_in[pick_ff] = 1'b0;
            if (int_rdata == '0) begin
               valid_in[pick_ff] = 1'b0;
            end
            res_in.kind     = KindExpired;
            res_in.handle   = handle_of(8'(pick_ff));
            res_in.status   = 1'b0;
            res_in.earliest = 1'b0;
            res_in.dvalid   = 1'b0;
            res_in.deadline = '0;
            res_in.delay    = '0;
            res_in.last     = 1'b0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         mode_ff      <= SCAN_MIN;
         min_delay_ff <= MinDelayReset;
         valid_ff     <= '0;
         due_ff       <= '0;
         cnt_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         mode_ff      <= mode_in;
         min_delay_ff <= min_delay_in;
         valid_ff     <= valid_in;
         due_ff       <= due_in;
         cnt_ff       <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      t_ff        <= t_in;
      intv_ff     <= intv_in;
      now_ff      <= now_in;
      any_ff      <= any_in;
      best_ff     <= best_in;
      free_any_ff <= free_any_in;
      free_ff     <= free_in;
      earliest_ff <= earliest_in;
      pick_any_ff <= pick_any_in;
      pick_ff     <= pick_in;
      pick_exp_ff <= pick_exp_in;
      res_ff      <= res_in;
   end

   assign rsp_tuser = res_ff.kind;
   assign rsp_tlast = res_ff.last;
   assign rsp_tdata = {1'b0, res_ff.delay, res_ff.deadline, res_ff.dvalid,
                       res_ff.earliest, res_ff.status, res_ff.handle};

   a_expired_not_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KindExpired |-> !rsp_tlast)
      else $error("expired timer word marked last");

   a_summary_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && (rsp_tuser == KindSummary || rsp_tuser == KindAddAck) |-> rsp_tlast)
      else $error("closing word not marked last");

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !rsp_tvalid)
      else $error("request taken while a result is pending");
endmodule
`default_nettype wire

>>> tb/tb_ordered_timer_queue.sv
// Testbench of the ordered timer queue: random and directed timer traffic against a scoreboard.
`default_nettype none
module tb_ordered_timer_queue;
   import otq_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   class timer_scoreboard;
      bit          live[16];
      bit [47:0]   expiry[16];
      bit [31:0]   reload[16];
      bit [15:0]   min_delay;
      result_type  pending[$];
      int          mismatches;
      int          results_seen;
      int          expired_seen;

      function new();
         min_delay = MinDelayReset;
      endfunction

      function void earliest_deadline(input bit [47:0] now, output bit dv,
                                      output bit [47:0] dl, output bit [47:0] dly);
         dv = 0; dl = 0; dly = 0;
         for (int i = 0; i < 16; i++)
            if (live[i] && (!dv || expiry[i] < dl)) begin
               dl = expiry[i];
               dv = 1;
            end
         if (dv) begin
            dly = (dl > now) ? dl - now : 48'd0;
            if (dly < {32'd0, min_delay}) dly = {32'd0, min_delay};
         end
      endfunction

      function void note_word(input logic func, input bit [47:0] t, input bit [31:0] iv,
                              input bit [47:0] now);
         result_type r;
         bit dv;
         bit [47:0] dl, dly;
         bit [48:0] sum;
         bit due[16];
         int slot, pick;
         if (func == FuncAdd) begin
            slot = -1;
            r = '0;
            r.kind = KindAddAck;
            r.earliest = 1;
            for (int i = 0; i < 16; i++)
               if (!live[i]) begin
                  if (slot < 0) slot = i;
               end else if (!(t < expiry[i])) r.earliest = 0;
            if (slot < 0) begin
               r.status = 1;
               r.earliest = 0;
            end else begin
               live[slot] = 1;
               expiry[slot] = t;
               reload[slot] = iv;
               r.handle = slot[3:0];
            end
            earliest_deadline(now, dv, dl, dly);
            r.dvalid = dv; r.deadline = dl; r.delay = dly; r.last = 1;
            pending = {pending, r};
            return;
         end
         for (int i = 0; i < 16; i++) due[i] = live[i] && expiry[i] <= t;
         forever begin
            pick = -1;
            for (int i = 0; i < 16; i++)
               if (due[i] && (pick < 0 || expiry[i] < expiry[pick])) pick = i;
            if (pick < 0) break;
            due[pick] = 0;
            r = '0;
            r.kind = KindExpired;
            r.handle = pick[3:0];
            pending = {pending, r};
            if (reload[pick] != 0) begin
               sum = {1'b0, t} + {17'd0, reload[pick]};
               expiry[pick] = sum[48] ? TimeMax : sum[47:0];
            end else live[pick] = 0;
         end
         earliest_deadline(t, dv, dl, dly);
         r = '0;
         r.kind = KindSummary;
         r.dvalid = dv; r.deadline = dl; r.delay = dly; r.last = 1;
         pending = {pending, r};
      endfunction

      function void check_word(input result_type got);
         result_type want;
         results_seen++;
         if (got.kind == KindExpired) expired_seen++;
         if (pending.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result word %p", got);
            return;
         end
         want = pending.pop_front();
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10) $display("mismatch: expected %p, got %p", want, got);
         end
      endfunction
   endclass

   logic         clock, reset;
   logic         req_tvalid, req_tready, req_tuser;
   logic [127:0] req_tdata;
   logic         rsp_tvalid, rsp_tready, rsp_tlast;
   logic [103:0] rsp_tdata;
   logic [KindW-1:0] rsp_tuser;
   logic         csr_valid, csr_ready;
   logic [DelayW-1:0] csr_data;

   timer_scoreboard board;
   bit [47:0] clock_now;
   int        hold_off;
   bit        stimulus_done;

   ordered_timer_queue i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   initial begin
      clock = 0;
      forever #10 clock = ~clock;
   end

   initial begin
      #50ms;
      $display("tb_ordered_timer_queue: done, errors");
      $finish;
   end

   task automatic send_word(input logic func, input bit [47:0] t, input bit [31:0] iv,
                            input bit [47:0] now, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(0, 19) : 0;
      if ($urandom_range(0, 3) == 0) gap = 0;
      @(negedge clock);
      repeat (gap) @(negedge clock);
      req_tvalid <= 1;
      req_tuser  <= func;
      req_tdata  <= {now, iv, t};
      do @(posedge clock); while (!req_tready);
      board.note_word(func, t, iv, now);
      @(negedge clock);
      req_tvalid <= 0;
   endtask

   task automatic write_min_delay(input bit [15:0] value);
      while (board.pending.size() != 0) @(negedge clock);
      repeat (60) @(negedge clock);
      csr_valid <= 1;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
      board.min_delay = value;
      @(negedge clock);
      csr_valid <= 0;
   endtask

   task automatic add_timer(input bit [47:0] t, input bit [31:0] iv, input bit gaps);
      send_word(FuncAdd, t, iv, clock_now, gaps);
   endtask

   task automatic expire_at(input bit [47:0] t, input bit gaps);
      send_word(FuncExpire, t, $urandom, 48'({$urandom, $urandom}), gaps);
   endtask

   // receiver: random stalls, plus one long hold-off while the sender keeps going
   initial begin
      int stall;
      rsp_tready = 0;
      forever begin
         @(negedge clock);
         if (hold_off > 0) begin
            rsp_tready <= 0;
            repeat (hold_off) @(negedge clock);
            hold_off = 0;
         end
         stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 19);
         if (stimulus_done && board.pending.size() == 0) stall = 0;
         if (stall > 0) begin
            rsp_tready <= 0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1;
         @(posedge clock);
         while (!(rsp_tvalid && rsp_tready)) @(posedge clock);
         board.check_word('{rsp_tuser, rsp_tdata[3:0], rsp_tdata[4], rsp_tdata[5],
                            rsp_tdata[6], rsp_tdata[54:7], rsp_tdata[102:55], rsp_tlast});
         if (rsp_tdata[103] !== 1'b0) begin
            board.mismatches++;
            if (board.mismatches <= 10) $display("pad bit set");
         end
      end
   end

   initial begin
      bit [47:0] t;
      bit [31:0] iv;
      int items;
      board = new();
      reset = 1;
      req_tvalid = 0; req_tuser = 0; req_tdata = '0;
      csr_valid = 0; csr_data = '0;
      hold_off = 0; stimulus_done = 0; clock_now = 1000;
      repeat (2) @(negedge clock);
      reset <= 0;

      // directed: empty expire, extremes, ties, full table, passed deadline, saturation
      expire_at(48'd0, 0);
      add_timer(TimeMax, 32'hFFFF_FFFF, 0);
      add_timer(48'd5000, 32'd0, 0);
      add_timer(48'd5000, 32'd0, 0);
      add_timer(48'd10, 32'd300, 0);
      send_word(FuncAdd, 48'd1100, 32'd0, TimeMax, 0);
      for (int i = 0; i < 12; i++) add_timer(48'd900 + i, i[0] ? 32'd0 : 32'd7, 0);
      add_timer(48'd1, 32'd1, 0);
      expire_at(48'd5000, 0);
      expire_at(TimeMax, 0);
      expire_at(48'hFFFF_FFFF_FFF0, 0);
      expire_at(TimeMax, 0);
      write_min_delay(16'hFFFF);
      add_timer(48'd2000, 32'd0, 0);
      expire_at(48'd1500, 0);
      write_min_delay(16'd0);
      expire_at(48'd1999, 0);
      expire_at(48'd2000, 0);
      items = 27;

      // long receiver hold-off while items keep arriving
      hold_off = 400;
      for (int i = 0; i < 20; i++) add_timer(clock_now + $urandom_range(0, 500), 32'd0, 0);
      expire_at(TimeMax, 0);
      items += 21;
      write_min_delay(16'd100);

      while (items < 260) begin
         if (items % 90 == 0) write_min_delay(16'($urandom));
         clock_now += $urandom_range(0, 300);
         if ($urandom_range(0, 2) == 0) begin
            t = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) : clock_now
                - $urandom_range(0, 200);
            expire_at(t > clock_now ? t : clock_now, 1);
         end else begin
            t = ($urandom_range(0, 15) == 0) ? 48'({$urandom, $urandom}) : clock_now
                + $urandom_range(0, 800);
            case ($urandom_range(0, 3))
               0: iv = 0;
               1: iv = $urandom;
               default: iv = $urandom_range(1, 600);
            endcase
            add_timer(t, iv, 1);
         end
         items++;
      end
      stimulus_done = 1;

      while (board.pending.size() != 0) @(negedge clock);
      repeat (200) @(negedge clock);
      $display("covered %0d input words, %0d result words, %0d timer expiries",
               items, board.results_seen, board.expired_seen);
      if (board.mismatches == 0 && board.pending.size() == 0)
         $display("tb_ordered_timer_queue: done, clean");
      else
         $display("tb_ordered_timer_queue: done, errors");
      $finish;
   end
endmodule
`default_nettype wire
